@@ rtl/rotary_encoder_button_decoder_defines.svh @@
// assertion macros for the rotary encoder and button decoder
`ifndef ROTARY_ENCODER_BUTTON_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_DEFINES_SVH

`ifndef SYNTH
`define REBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rebd assertion failed");
`define REBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rebd assertion failed");
`else
`define REBD_ASSERT(lbl, clk, rst_n, prop)
`define REBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rebd_pkg.sv @@
package rebd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 10;
  localparam int ENC_EV_W  = 3;
  localparam int BTN_EV_W  = 2;
  localparam int OUT_POS_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENC_MIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_MIN_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_LONG     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP  = 2'd3;

  localparam logic [ENC_EV_W-1:0] ENC_NONE     = 3'd0;
  localparam logic [ENC_EV_W-1:0] ENC_INC      = 3'd1;
  localparam logic [ENC_EV_W-1:0] ENC_DEC      = 3'd2;
  localparam logic [ENC_EV_W-1:0] ENC_INC_HELD = 3'd3;
  localparam logic [ENC_EV_W-1:0] ENC_DEC_HELD = 3'd4;

  localparam logic [BTN_EV_W-1:0] BTN_NONE  = 2'd0;
  localparam logic [BTN_EV_W-1:0] BTN_SHORT = 2'd1;
  localparam logic [BTN_EV_W-1:0] BTN_LONG  = 2'd2;

  localparam logic [CFG_W-1:0]  RST_ENC_MIN_LOW  = 16'd5;
  localparam logic [CFG_W-1:0]  RST_BTN_MIN_DOWN = 16'd20;
  localparam logic [CFG_W-1:0]  RST_BTN_LONG     = 16'd550;
  localparam logic [STEP_W-1:0] RST_COARSE_STEP  = 10'd10;

  typedef struct packed {
    logic step;
    logic up;
  } enc_step_t;

endpackage

@@ rtl/rebd_enc.sv @@
module rebd_enc #(
  parameter int TIME_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      enc_a_level,
  input  logic                      enc_b_level,
  input  logic [rebd_pkg::CFG_W-1:0] min_low_ticks,
  output rebd_pkg::enc_step_t       step_o
);
  import rebd_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic                 a_prev_r, a_prev_nxt;
  logic                 low_valid_r, low_valid_nxt;
  logic [TIME_BITS-1:0] low_ticks_r, low_ticks_nxt;
  logic [TIME_BITS-1:0] ticks_inc;

  always_comb begin
    ticks_inc = low_ticks_r;
    if (low_valid_r && (low_ticks_r != {TIME_BITS{1'b1}})) begin
      ticks_inc = low_ticks_r + TIME_BITS'(1);
    end
    a_prev_nxt    = enc_a_level;
    low_valid_nxt = low_valid_r;
    low_ticks_nxt = low_ticks_r;
    step_o.step   = 1'b0;
    step_o.up     = enc_b_level;
    if (a_prev_r && !enc_a_level) begin
      low_valid_nxt = 1'b1;
      low_ticks_nxt = '0;
    end else if (!a_prev_r) begin
      low_ticks_nxt = ticks_inc;
      if (enc_a_level) begin
        step_o.step   = low_valid_r && (CMP_W'(ticks_inc) > CMP_W'(min_low_ticks));
        low_valid_nxt = 1'b0;
        low_ticks_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_prev_r    <= 1'b1;
      low_valid_r <= 1'b0;
      low_ticks_r <= '0;
    end else if (accept) begin
      a_prev_r    <= a_prev_nxt;
      low_valid_r <= low_valid_nxt;
      low_ticks_r <= low_ticks_nxt;
    end
  end

endmodule

@@ rtl/rotary_encoder_button_decoder.sv @@
// channel  ports                                             direction
// in       in_valid/in_ready, enc_a, enc_b, button levels     request in
// out      out_valid/out_ready, enc_event, btn_event, position result out
// cfg      cfg_wr_en, cfg_index, cfg_wdata                    write only
//
// one tick per clock while in_ready is high; the result appears in the output register the cycle
// after the request is taken
// in_ready stays high while the output register is empty or being drained
// synchronous active-low reset restores the default register values
// and clears all tracking state
`include "rotary_encoder_button_decoder_defines.svh"

module rotary_encoder_button_decoder #(
  parameter int TIME_BITS = 16,
  parameter int POS_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_enc_a_level,
  input  logic                              in_enc_b_level,
  input  logic                              in_button_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rebd_pkg::ENC_EV_W-1:0]     out_enc_event,
  output logic [rebd_pkg::BTN_EV_W-1:0]     out_btn_event,
  output logic signed [rebd_pkg::OUT_POS_W-1:0] out_position,
  input  logic                              cfg_wr_en,
  input  logic [rebd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rebd_pkg::CFG_W-1:0]        cfg_wdata
);
  import rebd_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [CFG_W-1:0]  enc_min_low_r;
  logic [CFG_W-1:0]  btn_min_down_r;
  logic [CFG_W-1:0]  btn_long_r;
  logic [STEP_W-1:0] coarse_step_r;

  logic                 btn_prev_r, btn_prev_nxt;
  logic                 press_valid_r, press_valid_nxt;
  logic                 btn_held_r, btn_held_nxt;
  logic [TIME_BITS-1:0] down_ticks_r, down_ticks_nxt;
  logic [TIME_BITS-1:0] down_inc;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  delta;

  logic                out_valid_r;
  logic [ENC_EV_W-1:0] enc_event_r, enc_event_nxt;
  logic [BTN_EV_W-1:0] btn_event_r, btn_event_nxt;

  logic      accept;
  enc_step_t enc_step;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  rebd_enc #(
    .TIME_BITS (TIME_BITS)
  ) u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .enc_a_level   (in_enc_a_level),
    .enc_b_level   (in_enc_b_level),
    .min_low_ticks (enc_min_low_r),
    .step_o        (enc_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_min_low_r  <= RST_ENC_MIN_LOW;
      btn_min_down_r <= RST_BTN_MIN_DOWN;
      btn_long_r     <= RST_BTN_LONG;
      coarse_step_r  <= RST_COARSE_STEP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENC_MIN_LOW:  enc_min_low_r  <= cfg_wdata;
        CFG_BTN_MIN_DOWN: btn_min_down_r <= cfg_wdata;
        CFG_BTN_LONG:     btn_long_r     <= cfg_wdata;
        CFG_COARSE_STEP:  coarse_step_r  <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    down_inc = down_ticks_r;
    if (press_valid_r && (down_ticks_r != {TIME_BITS{1'b1}})) begin
      down_inc = down_ticks_r + TIME_BITS'(1);
    end
    btn_prev_nxt    = in_button_level;
    press_valid_nxt = press_valid_r;
    btn_held_nxt    = btn_held_r;
    down_ticks_nxt  = down_ticks_r;
    btn_event_nxt   = BTN_NONE;
    // button first
    if (btn_prev_r && !in_button_level) begin
      press_valid_nxt = 1'b1;
      btn_held_nxt    = 1'b1;
      down_ticks_nxt  = '0;
    end else if (!btn_prev_r) begin
      down_ticks_nxt = down_inc;
      if (in_button_level) begin
        if (press_valid_r && (CMP_W'(down_inc) > CMP_W'(btn_min_down_r))) begin
          btn_event_nxt = BTN_SHORT;
        end
        press_valid_nxt = 1'b0;
        btn_held_nxt    = 1'b0;
        down_ticks_nxt  = '0;
      end else if (press_valid_r && (CMP_W'(down_inc) >= CMP_W'(btn_long_r))) begin
        btn_event_nxt   = BTN_LONG;
        press_valid_nxt = 1'b0;
        btn_held_nxt    = 1'b0;
        down_ticks_nxt  = '0;
      end
    end
    // then encoder step
    enc_event_nxt = ENC_NONE;
    delta         = btn_held_nxt ? POS_BITS'(coarse_step_r) : POS_BITS'(1);
    pos_nxt       = pos_r;
    if (enc_step.step) begin
      if (btn_held_nxt) begin
        press_valid_nxt = 1'b0;
        down_ticks_nxt  = '0;
        enc_event_nxt   = enc_step.up ? ENC_INC_HELD : ENC_DEC_HELD;
      end else begin
        enc_event_nxt   = enc_step.up ? ENC_INC : ENC_DEC;
      end
      pos_nxt = enc_step.up ? (pos_r + delta) : (pos_r - delta);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_prev_r    <= 1'b1;
      press_valid_r <= 1'b0;
      btn_held_r    <= 1'b0;
      down_ticks_r  <= '0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        btn_prev_r    <= btn_prev_nxt;
        press_valid_r <= press_valid_nxt;
        btn_held_r    <= btn_held_nxt;
        down_ticks_r  <= down_ticks_nxt;
        pos_r         <= pos_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      enc_event_r <= enc_event_nxt;
      btn_event_r <= btn_event_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_enc_event = enc_event_r;
  assign out_btn_event = btn_event_r;
  assign out_position  = OUT_POS_W'(pos_r);

  `REBD_ASSERT(a_held_while_down, clk, rst_n, !btn_held_r || !btn_prev_r)
  `REBD_ASSERT(a_press_needs_held, clk, rst_n, !press_valid_r || btn_held_r)
  `REBD_ASSERT(a_coarse_cancels, clk, rst_n,
    !(out_valid_r && (enc_event_r == ENC_INC_HELD || enc_event_r == ENC_DEC_HELD))
    || (btn_held_r && !press_valid_r))
  `REBD_ASSERT(a_long_clears_held, clk, rst_n,
    !(out_valid_r && btn_event_r == BTN_LONG) || !btn_held_r)
  `REBD_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, out_valid_r)

endmodule

@@ verif/rotary_encoder_button_decoder_tb.sv @@
`timescale 1ns / 100ps

module rotary_encoder_button_decoder_tb;
  import rebd_pkg::*;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button;
  } tick_t;

  typedef struct packed {
    logic [ENC_EV_W-1:0]  enc_ev;
    logic [BTN_EV_W-1:0]  btn_ev;
    logic [OUT_POS_W-1:0] pos;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_enc_a_level = 1'b1;
  logic in_enc_b_level = 1'b0;
  logic in_button_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ENC_EV_W-1:0] out_enc_event;
  logic [BTN_EV_W-1:0] out_btn_event;
  logic signed [OUT_POS_W-1:0] out_position;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENC_MIN_LOW;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tick_t   tick_q[$];
  report_t report_q[$];
  int      mismatch_cnt = 0;
  int      idle_pct = 18;
  logic    req_taken = 1'b0;

  // decoder copy: settings
  logic [CFG_W-1:0]  min_low_cfg;
  logic [CFG_W-1:0]  min_down_cfg;
  logic [CFG_W-1:0]  long_cfg;
  logic [STEP_W-1:0] coarse_cfg;

  // decoder copy: tracking state
  logic        a_last;
  logic        btn_last;
  logic        low_live;
  logic [15:0] low_cnt;
  logic        press_live;
  logic        held;
  logic [15:0] down_cnt;
  logic [15:0] pos_acc;

  // stimulus generator state
  logic gen_a = 1'b1;
  logic gen_b = 1'b0;
  logic gen_btn = 1'b1;
  int   a_left = 3;
  int   btn_left = 5;

  rotary_encoder_button_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_enc_a_level  (in_enc_a_level),
    .in_enc_b_level  (in_enc_b_level),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_enc_event   (out_enc_event),
    .out_btn_event   (out_btn_event),
    .out_position    (out_position),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic report_t decode_tick(input tick_t t);
    report_t     r;
    logic [15:0] delta;
    r.enc_ev = ENC_NONE;
    r.btn_ev = BTN_NONE;
    // button first
    if (btn_last && !t.button) begin
      press_live = 1'b1;
      held = 1'b1;
      down_cnt = '0;
    end else if (!btn_last) begin
      if (press_live && down_cnt != 16'hFFFF) down_cnt = down_cnt + 16'd1;
      if (t.button) begin
        if (press_live && down_cnt > min_down_cfg) r.btn_ev = BTN_SHORT;
        press_live = 1'b0;
        held = 1'b0;
        down_cnt = '0;
      end else if (press_live && down_cnt >= long_cfg) begin
        r.btn_ev = BTN_LONG;
        press_live = 1'b0;
        held = 1'b0;
        down_cnt = '0;
      end
    end
    btn_last = t.button;
    // then encoder
    if (a_last && !t.enc_a) begin
      low_live = 1'b1;
      low_cnt = '0;
    end else if (!a_last) begin
      if (low_live && low_cnt != 16'hFFFF) low_cnt = low_cnt + 16'd1;
      if (t.enc_a) begin
        if (low_live && low_cnt > min_low_cfg) begin
          if (held) begin
            delta = {{(16 - STEP_W){1'b0}}, coarse_cfg};
            press_live = 1'b0;
            down_cnt = '0;
            r.enc_ev = t.enc_b ? ENC_INC_HELD : ENC_DEC_HELD;
          end else begin
            delta = 16'd1;
            r.enc_ev = t.enc_b ? ENC_INC : ENC_DEC;
          end
          pos_acc = t.enc_b ? pos_acc + delta : pos_acc - delta;
        end
        low_live = 1'b0;
        low_cnt = '0;
      end
    end
    a_last = t.enc_a;
    r.pos = pos_acc;
    return r;
  endfunction

  // result check and request capture
  always @(posedge clk) begin : mon
    report_t want;
    if (!rst_n) begin
      min_low_cfg = RST_ENC_MIN_LOW;
      min_down_cfg = RST_BTN_MIN_DOWN;
      long_cfg = RST_BTN_LONG;
      coarse_cfg = RST_COARSE_STEP;
      a_last = 1'b1;
      btn_last = 1'b1;
      low_live = 1'b0;
      low_cnt = '0;
      press_live = 1'b0;
      held = 1'b0;
      down_cnt = '0;
      pos_acc = '0;
      req_taken = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENC_MIN_LOW:  min_low_cfg = cfg_wdata;
          CFG_BTN_MIN_DOWN: min_down_cfg = cfg_wdata;
          CFG_BTN_LONG:     long_cfg = cfg_wdata;
          CFG_COARSE_STEP:  coarse_cfg = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: enc %0d btn %0d pos %0d",
                     out_enc_event, out_btn_event, out_position);
        end else begin
          want = report_q.pop_front();
          if (out_enc_event !== want.enc_ev || out_btn_event !== want.btn_ev ||
              out_position !== want.pos) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: enc %0d/%0d btn %0d/%0d pos %0d/%0d (exp/got)",
                       want.enc_ev, out_enc_event, want.btn_ev, out_btn_event,
                       $signed(want.pos), out_position);
          end
        end
      end
      req_taken = in_valid && in_ready;
      if (req_taken)
        report_q.push_back(decode_tick({in_enc_a_level, in_enc_b_level, in_button_level}));
    end
  end

  // request driver
  always @(negedge clk) begin : drv
    tick_t    nxt;
    static logic drain_hold = 1'b0;
    static logic drained_once = 1'b0;
    static int   sent_cnt = 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      if (drain_hold && report_q.size() == 0) begin
        drain_hold = 1'b0;
      end else if (!drain_hold && tick_q.size() != 0 &&
                   ($urandom_range(299) == 0 || (!drained_once && sent_cnt >= 700))) begin
        drain_hold = 1'b1;
        drained_once = 1'b1;
      end
      if (!drain_hold && tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = tick_q.pop_front();
        in_valid <= 1'b1;
        in_enc_a_level <= nxt.enc_a;
        in_enc_b_level <= nxt.enc_b;
        in_button_level <= nxt.button;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic add_tick(input logic a, input logic b, input logic btn);
    tick_q.push_back({a, b, btn});
  endtask

  task automatic set_config(input logic [CFG_W-1:0] low_t, input logic [CFG_W-1:0] down_t,
                            input logic [CFG_W-1:0] long_t, input logic [CFG_W-1:0] step_w);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENC_MIN_LOW;
    cfg_wdata <= low_t;
    @(negedge clk);
    cfg_index <= CFG_BTN_MIN_DOWN;
    cfg_wdata <= down_t;
    @(negedge clk);
    cfg_index <= CFG_BTN_LONG;
    cfg_wdata <= long_t;
    @(negedge clk);
    cfg_index <= CFG_COARSE_STEP;
    cfg_wdata <= step_w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // run length near a threshold, some too short
  function automatic int pick_run(input int thr);
    int n;
    case ($urandom_range(9))
      0, 1, 2:    n = $urandom_range(1, 3);
      3, 4, 5, 6: n = thr + $urandom_range(0, 2);
      default:    n = thr + $urandom_range(1, 6);
    endcase
    return (n < 1) ? 1 : n;
  endfunction

  task automatic gen_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      if (a_left <= 0) begin
        gen_a = !gen_a;
        if (gen_a) begin
          a_left = $urandom_range(1, 4);
        end else begin
          a_left = pick_run(int'(min_low_cfg));
          gen_b = 1'($urandom_range(1));
        end
      end
      if (btn_left <= 0) begin
        gen_btn = !gen_btn;
        if (gen_btn) btn_left = $urandom_range(1, 25);
        else btn_left = pick_run(($urandom_range(9) < 2) ? int'(long_cfg) : int'(min_down_cfg));
      end
      if ($urandom_range(19) == 0)
        add_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        add_tick(gen_a, ($urandom_range(15) == 0) ? !gen_b : gen_b, gen_btn);
      a_left--;
      btn_left--;
    end
  endtask

  initial begin : stim
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: steps, held steps, short and long press, both in one tick
    set_config(16'd0, 16'd1, 16'd3, 16'd1000);
    add_tick(1, 0, 1);
    add_tick(0, 0, 1);
    add_tick(1, 0, 1);
    add_tick(0, 1, 0);
    add_tick(1, 1, 0);
    add_tick(1, 1, 0);
    add_tick(1, 1, 1);
    add_tick(1, 1, 0);
    add_tick(1, 1, 0);
    add_tick(1, 1, 1);
    add_tick(1, 0, 0);
    add_tick(1, 0, 0);
    add_tick(1, 0, 0);
    add_tick(0, 0, 0);
    add_tick(1, 0, 0);
    add_tick(1, 0, 1);
    add_tick(1, 0, 0);
    add_tick(0, 1, 0);
    add_tick(0, 1, 0);
    add_tick(1, 1, 1);
    add_tick(1, 1, 0);
    add_tick(0, 0, 0);
    add_tick(1, 0, 0);
    add_tick(1, 0, 1);
    gen_ticks(280);
    wait_drained();

    set_config(16'd1, 16'd0, 16'd1, 16'd1);
    gen_ticks(300);
    wait_drained();

    // zero thresholds and zero coarse step
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    gen_ticks(250);
    wait_drained();

    // reset values, no idling
    idle_pct = 0;
    set_config(RST_ENC_MIN_LOW, RST_BTN_MIN_DOWN, RST_BTN_LONG,
               {{(CFG_W - STEP_W){1'b0}}, RST_COARSE_STEP});
    gen_ticks(360);
    wait_drained();
    idle_pct = 18;

    // top thresholds, long low and long hold give no events
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000);
    add_tick(1, 1, 1);
    add_tick(1, 1, 1);
    add_tick(0, 1, 0);
    repeat (30) add_tick(0, 1, 0);
    add_tick(1, 1, 0);
    add_tick(1, 0, 1);
    gen_a = 1'b1;
    gen_btn = 1'b1;
    a_left = 2;
    btn_left = 3;
    wait_drained();

    // coarse step beyond range, upper write bits set
    set_config(16'd3, 16'd6, 16'd30, {6'h2A, 10'h3FF});
    gen_ticks(400);
    wait_drained();

    set_config(16'd2, 16'd4, 16'd12, 16'd500);
    gen_ticks(300);
    wait_drained();

    if (mismatch_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rebd_pkg.sv
rtl/rebd_enc.sv
rtl/rotary_encoder_button_decoder.sv
verif/rotary_encoder_button_decoder_tb.sv
